@@ hw/rtl/tbam_pkg.sv @@
// ----------------------------------------------------------------------------
// tbam_pkg
// Types and constants shared by the touch button activity monitor.
// ----------------------------------------------------------------------------
package tbam_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned MaskW  = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    ACT_IDLE      = 2'd0,
    ACT_PRESSED   = 2'd1,
    ACT_RELEASED  = 2'd2,
    ACT_COUNTDOWN = 2'd3
  } act_state_t;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_PRESS   = 2'd1,
    EVT_RELEASE = 2'd2
  } btn_event_t;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_RED   = 2'd1,
    LED_GREEN = 2'd2,
    LED_BLUE  = 2'd3
  } led_t;

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_MOISTURE_OFFSET = 3'd0,
    REG_BUTTON1_OFFSET  = 3'd1,
    REG_BUTTON2_OFFSET  = 3'd2,
    REG_BUTTON3_OFFSET  = 3'd3,
    REG_TOUCH_LEVEL     = 3'd4,
    REG_COUNTDOWN_TICKS = 3'd5
  } reg_idx_t;

  localparam count_t RstMoistureOffset = 16'd166;
  localparam count_t RstButton1Offset  = 16'd57;
  localparam count_t RstButton2Offset  = 16'd68;
  localparam count_t RstButton3Offset  = 16'd65;
  localparam count_t RstTouchLevel     = 16'd100;
  localparam count_t RstCountdownTicks = 16'd3000;

  localparam count_t MoistRedLimit   = 16'd500;
  localparam count_t MoistGreenLimit = 16'd1000;

  localparam logic [1:0] PadMoisture = 2'd0;
  localparam logic [1:0] PadButton1  = 2'd1;
  localparam logic [1:0] PadButton3  = 2'd3;

  typedef struct packed {
    count_t moisture_offset;
    count_t button1_offset;
    count_t button2_offset;
    count_t button3_offset;
    count_t touch_level;
    count_t countdown_ticks;
  } cfg_t;

  function automatic led_t moisture_colour(input count_t v);
    if (v < MoistRedLimit) begin
      return LED_RED;
    end else if (v < MoistGreenLimit) begin
      return LED_GREEN;
    end
    return LED_BLUE;
  endfunction

endpackage

@@ hw/rtl/tbam_if.sv @@
// ----------------------------------------------------------------------------
// tbam_in_if / tbam_out_if
// Valid/ready channels for measurement words and result words.
// ----------------------------------------------------------------------------
interface tbam_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [1:0]                    pad;
  logic [tbam_pkg::CountW-1:0]   raw_count;

  modport source (output valid, output mode, output pad, output raw_count, input ready);
  modport sink   (input valid, input mode, input pad, input raw_count, output ready);
endinterface

interface tbam_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    activity_state;
  logic [tbam_pkg::MaskW-1:0]    pressed_mask;
  logic [1:0]                    button_event;
  logic [tbam_pkg::CountW-1:0]   corrected_value;
  logic [1:0]                    led_color;
  logic                          moisture_flash;
  logic                          recalibrate_request;

  modport source (
    output valid, output activity_state, output pressed_mask, output button_event,
    output corrected_value, output led_color, output moisture_flash,
    output recalibrate_request, input ready
  );
  modport sink (
    input valid, input activity_state, input pressed_mask, input button_event,
    input corrected_value, input led_color, input moisture_flash,
    input recalibrate_request, output ready
  );
endinterface

@@ hw/rtl/tbam_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tbam_cfg_regs
// APB-style register file holding pad offsets, threshold and countdown length.
// ----------------------------------------------------------------------------
module tbam_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbam_pkg::AddrW-1:0]  paddr,
  input  logic [tbam_pkg::DataW-1:0]  pwdata,
  output logic [tbam_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output tbam_pkg::cfg_t              cfg
);
  import tbam_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;
  count_t   wval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wval   = pwdata[CountW-1:0];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.moisture_offset <= RstMoistureOffset;
      cfg_r.button1_offset  <= RstButton1Offset;
      cfg_r.button2_offset  <= RstButton2Offset;
      cfg_r.button3_offset  <= RstButton3Offset;
      cfg_r.touch_level     <= RstTouchLevel;
      cfg_r.countdown_ticks <= RstCountdownTicks;
    end else if (wr_en) begin
      case (idx)
        REG_MOISTURE_OFFSET: cfg_r.moisture_offset <= wval;
        REG_BUTTON1_OFFSET:  cfg_r.button1_offset  <= wval;
        REG_BUTTON2_OFFSET:  cfg_r.button2_offset  <= wval;
        REG_BUTTON3_OFFSET:  cfg_r.button3_offset  <= wval;
        REG_TOUCH_LEVEL:     cfg_r.touch_level     <= wval;
        REG_COUNTDOWN_TICKS: cfg_r.countdown_ticks <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_MOISTURE_OFFSET: prdata[CountW-1:0] = cfg_r.moisture_offset;
      REG_BUTTON1_OFFSET:  prdata[CountW-1:0] = cfg_r.button1_offset;
      REG_BUTTON2_OFFSET:  prdata[CountW-1:0] = cfg_r.button2_offset;
      REG_BUTTON3_OFFSET:  prdata[CountW-1:0] = cfg_r.button3_offset;
      REG_TOUCH_LEVEL:     prdata[CountW-1:0] = cfg_r.touch_level;
      REG_COUNTDOWN_TICKS: prdata[CountW-1:0] = cfg_r.countdown_ticks;
      default: prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/touch_button_activity_monitor.sv @@
// ----------------------------------------------------------------------------
// touch_button_activity_monitor
// Pad offset correction, touch detection, LED colour and activity machine.
// ----------------------------------------------------------------------------
// Each input word is either a charge-time count for one pad or a millisecond
// tick. A word is captured in an input register, processed against the block
// state and written to a result register, so the block takes one word per
// clock while the output is not stalled. The input side keeps accepting while
// the input register is empty or moves on into the result register in the
// same cycle; a waiting result holds one more word in the input register and
// then stalls the input.
module touch_button_activity_monitor #(
  parameter int NUM_BUTTONS = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tbam_in_if.sink                     in_ch,
  tbam_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tbam_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [tbam_pkg::DataW-1:0]  cfg_pwdata,
  output logic [tbam_pkg::DataW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import tbam_pkg::*;

  localparam logic [3:0] NumBtn = 4'(NUM_BUTTONS);

  cfg_t cfg;

  tbam_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input register
  logic       s1_valid_r;
  logic       s1_tick_r;
  logic [1:0] s1_pad_r;
  count_t     s1_raw_r;

  // block state
  act_state_t mode_r, mode_nxt, mode_mid;
  logic [MaskW-1:0] pressed_r, pressed_nxt;
  count_t     moist_r, moist_nxt;
  count_t     left_r, left_nxt;
  logic       run_r, run_nxt;
  logic       exp_r, exp_nxt;
  led_t       led_r, led_nxt, led_mid;

  // result register
  logic             out_valid_r;
  act_state_t       out_state_r;
  logic [MaskW-1:0] out_mask_r;
  btn_event_t       out_event_r;
  count_t           out_corr_r;
  led_t             out_led_r;
  logic             out_flash_r;
  logic             out_recal_r;

  logic       out_free, s1_fire, in_fire;
  logic       is_button, end_scan;
  logic [MaskW-1:0] bit_sel;
  count_t     offset, corrected;
  logic [CountW:0] diff;
  logic       above, below;
  btn_event_t evt;
  led_t       shown;
  logic       flash, recal;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    case (s1_pad_r)
      2'd0:    offset = cfg.moisture_offset;
      2'd1:    offset = cfg.button1_offset;
      2'd2:    offset = cfg.button2_offset;
      default: offset = cfg.button3_offset;
    endcase
  end

  // borrow out of the subtract means clamp at zero
  assign diff      = {1'b0, s1_raw_r} - {1'b0, offset};
  assign corrected = s1_tick_r ? '0 : (diff[CountW] ? '0 : diff[CountW-1:0]);
  assign is_button = !s1_tick_r && (s1_pad_r != PadMoisture)
                     && ({2'b00, s1_pad_r} <= NumBtn);
  assign end_scan  = !s1_tick_r && (s1_pad_r == PadButton3);
  assign bit_sel   = MaskW'(1) << (s1_pad_r - 2'd1);
  assign above     = corrected > cfg.touch_level;
  assign below     = corrected < cfg.touch_level;

  // button detection, before the end of scan step
  always_comb begin
    mode_mid    = mode_r;
    pressed_nxt = pressed_r;
    led_mid     = led_r;
    evt         = EVT_NONE;
    recal       = 1'b0;
    if (is_button) begin
      if (above) begin
        mode_mid = ACT_PRESSED;
        if ((pressed_r & bit_sel) == '0) begin
          pressed_nxt = pressed_r | bit_sel;
          evt         = EVT_PRESS;
        end
        if (s1_pad_r == PadButton1) begin
          led_mid = moisture_colour(moist_r);
        end
      end else if (below && ((pressed_r & bit_sel) != '0)) begin
        mode_mid    = ACT_RELEASED;
        pressed_nxt = pressed_r & ~bit_sel;
        evt         = EVT_RELEASE;
        if (s1_pad_r == PadButton1) begin
          led_mid = LED_OFF;
        end else if (s1_pad_r == PadButton3) begin
          recal = 1'b1;
        end
      end
    end
  end

  // activity machine and countdown: next state
  always_comb begin
    mode_nxt  = mode_mid;
    led_nxt   = led_mid;
    moist_nxt = moist_r;
    left_nxt  = left_r;
    run_nxt   = run_r;
    exp_nxt   = exp_r;
    if (s1_tick_r) begin
      if (run_r) begin
        if (left_r <= count_t'(1)) begin
          left_nxt = cfg.countdown_ticks;
          exp_nxt  = 1'b1;
        end else begin
          left_nxt = left_r - count_t'(1);
        end
      end
    end else begin
      if (s1_pad_r == PadMoisture) begin
        moist_nxt = corrected;
      end
      if (end_scan) begin
        case (mode_mid)
          ACT_IDLE:     led_nxt = LED_OFF;
          ACT_PRESSED:  run_nxt = 1'b0;
          ACT_RELEASED: begin
            mode_nxt = ACT_COUNTDOWN;
            left_nxt = cfg.countdown_ticks;
            run_nxt  = 1'b1;
            exp_nxt  = 1'b0;
          end
          ACT_COUNTDOWN: begin
            if (exp_r) begin
              run_nxt  = 1'b0;
              exp_nxt  = 1'b0;
              mode_nxt = ACT_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // activity machine: outputs
  always_comb begin
    flash = 1'b0;
    shown = led_mid;
    if (end_scan && (mode_mid == ACT_IDLE)) begin
      flash = 1'b1;
      shown = moisture_colour(moist_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= ACT_IDLE;
      pressed_r   <= '0;
      moist_r     <= '0;
      left_r      <= '0;
      run_r       <= 1'b0;
      exp_r       <= 1'b0;
      led_r       <= LED_OFF;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        mode_r    <= mode_nxt;
        pressed_r <= pressed_nxt;
        moist_r   <= moist_nxt;
        left_r    <= left_nxt;
        run_r     <= run_nxt;
        exp_r     <= exp_nxt;
        led_r     <= led_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r <= in_ch.mode;
      s1_pad_r  <= in_ch.pad;
      s1_raw_r  <= in_ch.raw_count;
    end
    if (s1_fire) begin
      out_state_r <= mode_nxt;
      out_mask_r  <= pressed_nxt;
      out_event_r <= evt;
      out_corr_r  <= corrected;
      out_led_r   <= shown;
      out_flash_r <= flash;
      out_recal_r <= recal;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.activity_state      = out_state_r;
  assign out_ch.pressed_mask        = out_mask_r;
  assign out_ch.button_event        = out_event_r;
  assign out_ch.corrected_value     = out_corr_r;
  assign out_ch.led_color           = out_led_r;
  assign out_ch.moisture_flash      = out_flash_r;
  assign out_ch.recalibrate_request = out_recal_r;

`ifndef SYNTH
  a_tick_keeps_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_tick_r) |=> (pressed_r == $past(pressed_r)))
    else $error("tick word changed the pressed flags");

  a_recal_after_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_recal_r) |-> (!out_mask_r[2] && out_event_r == EVT_RELEASE))
    else $error("recalibration request without a button 3 release");

  a_flash_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_flash_r) |-> (out_state_r == ACT_IDLE))
    else $error("moisture flash outside idle");

  a_press_sets_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == EVT_PRESS) |-> (out_mask_r != '0))
    else $error("press reported with no button held");
`endif

endmodule
